@@ src/cut_interval_recorder_unit_defines.svh @@
// Assertion macros for the recorder RTL.
`ifndef CUT_INTERVAL_RECORDER_UNIT_DEFINES_SVH
`define CUT_INTERVAL_RECORDER_UNIT_DEFINES_SVH

// Check cons in the same cycle that ante holds.
`define CIR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cut interval recorder: same-cycle check failed");

// Check cons in the cycle after ante holds.
`define CIR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cut interval recorder: next-cycle check failed");

`endif

@@ src/cir_pkg.sv @@
package cir_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } cir_state_e;

  typedef struct packed {
    logic load;
    logic read;
    logic update;
  } cir_cmd_t;

  localparam logic [4:0]  NUM_CUTS_RESET = 5'd16;
  localparam logic [31:0] TALLY_MAX      = 32'hFFFF_FFFF;

endpackage

@@ src/cir_ctrl.sv @@
module cir_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cir_pkg::cir_cmd_t cmd_o
);
  import cir_pkg::*;

  cir_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DONE;
      ST_DONE:   if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = in_valid_i;
      end
      ST_READ:   cmd_o.read = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_DONE:   out_valid_o = 1'b1;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/cir_datapath.sv @@
module cir_datapath #(
  parameter int MaxCutTypes = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cir_pkg::cir_cmd_t cmd_i,
  input  logic              num_cuts_we_i,
  input  logic [4:0]        num_cuts_i,
  input  logic [3:0]        cut_type_i,
  input  logic signed [31:0] cut_value_i,
  input  logic [31:0]       event_number_i,
  output logic              accepted_o,
  output logic              closed_valid_o,
  output logic signed [31:0] closed_value_o,
  output logic [31:0]       closed_start_o,
  output logic              opened_valid_o,
  output logic [31:0]       tally_count_o
);
  import cir_pkg::*;

  localparam int IdxW = $clog2(MaxCutTypes);

  logic [4:0] num_cuts_q;

  // latched item
  logic [IdxW-1:0] idx_q;
  logic [31:0]     val_q;
  logic [31:0]     ev_q;
  logic            hit_q;

  // per-type tables
  logic [31:0] value_mem [MaxCutTypes];
  logic [31:0] start_mem [MaxCutTypes];
  logic [31:0] tally_mem [MaxCutTypes];
  logic [MaxCutTypes-1:0] open_q;
  logic [MaxCutTypes-1:0] tally_ok_q;

  // registered read data
  logic [31:0] rd_value_q;
  logic [31:0] rd_start_q;
  logic [31:0] rd_tally_q;
  logic        rd_open_q;
  logic        rd_tok_q;

  logic        in_range;
  logic        nonzero;
  logic        differs;
  logic        closed;
  logic        opened;
  logic [31:0] tally_cur;
  logic [31:0] tally_new;
  logic        wr_en;

  assign in_range = ({1'b0, cut_type_i} < num_cuts_q) &&
                    (32'(cut_type_i) < 32'(MaxCutTypes));

  assign nonzero   = (val_q != 32'd0);
  assign differs   = (rd_value_q != val_q);
  assign tally_cur = rd_tok_q ? rd_tally_q : 32'd0;
  assign tally_new = (nonzero && (tally_cur != TALLY_MAX)) ? tally_cur + 32'd1 : tally_cur;
  assign closed    = rd_open_q && (!nonzero || differs);
  assign opened    = nonzero && (!rd_open_q || differs);
  assign wr_en     = cmd_i.update && hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cuts_q <= NUM_CUTS_RESET;
    end else if (num_cuts_we_i) begin
      num_cuts_q <= num_cuts_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= '0;
      tally_ok_q <= '0;
    end else if (wr_en) begin
      open_q[idx_q]     <= nonzero;
      tally_ok_q[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= IdxW'(cut_type_i);
      val_q <= cut_value_i;
      ev_q  <= event_number_i;
      hit_q <= in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_value_q <= value_mem[idx_q];
      rd_start_q <= start_mem[idx_q];
      rd_tally_q <= tally_mem[idx_q];
      rd_open_q  <= open_q[idx_q];
      rd_tok_q   <= tally_ok_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tally_mem[idx_q] <= tally_new;
    end
    if (wr_en && opened) begin
      value_mem[idx_q] <= val_q;
      start_mem[idx_q] <= ev_q;
    end
  end

  // Ignored types report all zeros.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      accepted_o     <= hit_q;
      closed_valid_o <= hit_q && closed;
      closed_value_o <= (hit_q && closed) ? rd_value_q : 32'd0;
      closed_start_o <= (hit_q && closed) ? rd_start_q : 32'd0;
      opened_valid_o <= hit_q && opened;
      tally_count_o  <= hit_q ? tally_new : 32'd0;
    end
  end

endmodule

@@ src/cut_interval_recorder_unit.sv @@
// Cut interval recorder. For each cut type below num_cuts it tracks whether a
// cut condition interval is open, the value of that interval, the event it
// started at, and a saturating tally of items with a nonzero value. Every
// accepted item yields exactly one result item: accepted is 0 (and every
// other field 0) for a type at or above num_cuts, otherwise the result tells
// which interval was closed at this event and whether a new one was opened
// with the item's value. Each item goes through load, table read, update and
// result hold (through any output stall), as the per-type tables sit in a
// memory with a registered read port and take a read-modify-write. The next
// item is taken once the result has left. num_cuts resets to 16 and is written
// through num_cuts_we_i; the user must write it only while idle, which the
// block does not enforce. The tables need no clearing pass after reset.
`include "cut_interval_recorder_unit_defines.svh"

module cut_interval_recorder_unit #(
  parameter int MAX_CUT_TYPES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               num_cuts_we_i,
  input  logic [4:0]         num_cuts_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         cut_type_i,
  input  logic signed [31:0] cut_value_i,
  input  logic [31:0]        event_number_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic               closed_valid_o,
  output logic signed [31:0] closed_value_o,
  output logic [31:0]        closed_start_o,
  output logic               opened_valid_o,
  output logic [31:0]        tally_count_o
);
  import cir_pkg::*;

  cir_cmd_t cmd;

  // Sequence load, read, update and hold of one item at a time.
  cir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Hold the per-type tables and build the result.
  cir_datapath #(
    .MaxCutTypes (MAX_CUT_TYPES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .num_cuts_we_i  (num_cuts_we_i),
    .num_cuts_i     (num_cuts_i),
    .cut_type_i     (cut_type_i),
    .cut_value_i    (cut_value_i),
    .event_number_i (event_number_i),
    .accepted_o     (accepted_o),
    .closed_valid_o (closed_valid_o),
    .closed_value_o (closed_value_o),
    .closed_start_o (closed_start_o),
    .opened_valid_o (opened_valid_o),
    .tally_count_o  (tally_count_o)
  );

  // An accepted item blocks further input until its result is gone.
  `CIR_ASSERT_NEXT(a_block_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // Never ready for input while a result is pending.
  `CIR_ASSERT_IMPL(a_one_in_flight, out_valid_o, in_stall_o)
  // An ignored type reports nothing closed or opened and a zero tally.
  `CIR_ASSERT_IMPL(a_ignored_zero, out_valid_o && !accepted_o,
                   !closed_valid_o && !opened_valid_o && tally_count_o == 32'd0)
  // A fresh interval only opens on a nonzero value, which leaves the tally nonzero.
  `CIR_ASSERT_IMPL(a_open_has_tally, out_valid_o && opened_valid_o,
                   accepted_o && tally_count_o != 32'd0)

endmodule

@@ tb/cut_interval_recorder_unit_tb.sv @@
module cut_interval_recorder_unit_tb;

  import cir_pkg::*;

  localparam int CUT_TYPES = 16;
  localparam int CLK_PERIOD = 8;
  // Extra clocks to wait once every result is back, when draining.
  localparam int DRAIN_CYCLES = 8;

  // One condition report as it enters the block.
  typedef struct packed {
    logic [3:0]         ctype;
    logic signed [31:0] value;
    logic [31:0]        evnum;
  } cut_report_t;

  // What the block reports back for one condition report.
  typedef struct packed {
    logic               accepted;
    logic               closed_valid;
    logic signed [31:0] closed_value;
    logic [31:0]        closed_start;
    logic               opened_valid;
    logic [31:0]        tally;
  } interval_rec_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               num_cuts_we_i = 1'b0;
  logic [4:0]         num_cuts_i = NUM_CUTS_RESET;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         cut_type_i = '0;
  logic signed [31:0] cut_value_i = '0;
  logic [31:0]        event_number_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               accepted_o;
  logic               closed_valid_o;
  logic signed [31:0] closed_value_o;
  logic [31:0]        closed_start_o;
  logic               opened_valid_o;
  logic [31:0]        tally_count_o;

  cut_interval_recorder_unit #(
    .MAX_CUT_TYPES(CUT_TYPES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_cuts_we_i (num_cuts_we_i),
    .num_cuts_i    (num_cuts_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cut_type_i    (cut_type_i),
    .cut_value_i   (cut_value_i),
    .event_number_i(event_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .accepted_o    (accepted_o),
    .closed_valid_o(closed_valid_o),
    .closed_value_o(closed_value_o),
    .closed_start_o(closed_start_o),
    .opened_valid_o(opened_valid_o),
    .tally_count_o (tally_count_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the per-type interval tables and num_cuts.
  // ---------------------------------------------------------------------------
  logic [4:0]  cuts_in_use = NUM_CUTS_RESET;
  logic        iv_open  [CUT_TYPES];
  logic [31:0] iv_value [CUT_TYPES];
  logic [31:0] iv_start [CUT_TYPES];
  logic [31:0] fail_cnt [CUT_TYPES];

  cut_report_t   report_q[$];     // items waiting for the driver
  interval_rec_t expected_rec_q[$]; // predicted results, oldest first

  int errors = 0;
  int reports_sent = 0;
  int reports_ignored = 0;
  int intervals_opened = 0;
  int intervals_closed = 0;
  int intervals_kept = 0;
  int results_seen = 0;
  int settings_used = 0;

  // Handshake pacing, set by the stimulus sequence.
  int  send_idle_pct = 32;
  int  recv_stall_pct = 32;

  initial begin
    for (int i = 0; i < CUT_TYPES; i++) begin
      iv_open[i]  = 1'b0;
      iv_value[i] = '0;
      iv_start[i] = '0;
      fail_cnt[i] = '0;
    end
  end

  // Apply one report to the interval tables and return the result it causes.
  function automatic interval_rec_t record_report(cut_report_t r);
    interval_rec_t rec;
    int c;
    rec = '0;
    c = int'(r.ctype);
    // A type outside the active range leaves everything alone and reports all zero.
    if ({1'b0, r.ctype} >= cuts_in_use) begin
      reports_ignored++;
      return rec;
    end
    rec.accepted = 1'b1;
    if (r.value != 0) begin
      if (fail_cnt[c] != TALLY_MAX) fail_cnt[c]++;
      if (iv_open[c] && iv_value[c] == r.value) begin
        // Same value: keep the interval running.
        intervals_kept++;
      end else begin
        if (iv_open[c]) begin
          rec.closed_valid = 1'b1;
          rec.closed_value = iv_value[c];
          rec.closed_start = iv_start[c];
          intervals_closed++;
        end
        rec.opened_valid = 1'b1;
        iv_open[c]  = 1'b1;
        iv_value[c] = r.value;
        iv_start[c] = r.evnum;
        intervals_opened++;
      end
    end else if (iv_open[c]) begin
      // Condition gone: close the running interval at this event.
      rec.closed_valid = 1'b1;
      rec.closed_value = iv_value[c];
      rec.closed_start = iv_start[c];
      iv_open[c] = 1'b0;
      intervals_closed++;
    end
    rec.tally = fail_cnt[c];
    return rec;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next queued item when the channel is free, hold it
  // while stalled, and predict the result at the edge that accepts it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : report_driver
    cut_report_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_rec_q.insert(expected_rec_q.size(),
                              record_report({cut_type_i, cut_value_i, event_number_i}));
        reports_sent++;
      end
      // Advance only when nothing is held on the channel.
      if (!in_valid_i || !in_stall_o) begin
        if (report_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = report_q.pop_front();
          cut_type_i     <= nxt.ctype;
          cut_value_i    <= nxt.value;
          event_number_i <= nxt.evnum;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take each result at its accepting edge and compare it with the
  // oldest prediction; randomize the stall for the next cycle.
  // ---------------------------------------------------------------------------
  task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    interval_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_rec_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, got %0b %0b %h %h %0b %h",
                 $time, accepted_o, closed_valid_o, closed_value_o, closed_start_o,
                 opened_valid_o, tally_count_o);
      end else begin
        want = expected_rec_q.pop_front();
        flag_field("accepted", 32'(want.accepted), 32'(accepted_o));
        flag_field("closed_valid", 32'(want.closed_valid), 32'(closed_valid_o));
        flag_field("closed_value", want.closed_value, closed_value_o);
        flag_field("closed_start", want.closed_start, closed_start_o);
        flag_field("opened_valid", 32'(want.opened_valid), 32'(opened_valid_o));
        flag_field("tally_count", want.tally, tally_count_o);
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic signed [31:0] last_value [CUT_TYPES];
  logic [31:0]        next_event = '0;

  task automatic queue_report(int ctype, logic signed [31:0] value, logic [31:0] evnum);
    cut_report_t r;
    r.ctype = ctype[3:0];
    r.value = value;
    r.evnum = evnum;
    report_q.insert(report_q.size(), r);
  endtask

  // Hold the sender until every queued item has gone and every result has come back.
  task automatic drain_all();
    do @(negedge clk_i);
    while (report_q.size() != 0 || in_valid_i || expected_rec_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Change num_cuts; only called with the block idle.
  task automatic set_num_cuts(logic [4:0] v);
    @(posedge clk_i);
    num_cuts_we_i <= 1'b1;
    num_cuts_i    <= v;
    @(posedge clk_i);
    num_cuts_we_i <= 1'b0;
    cuts_in_use = v;
    settings_used++;
  endtask

  // Mostly well-formed interval traffic on the active types: values repeat
  // often so intervals stay open, change now and then, and zeros close them.
  // Some items land on inactive types or carry fully random values.
  task automatic queue_random_reports(int n);
    int active;
    int t;
    int roll;
    logic signed [31:0] v;
    active = (cuts_in_use > CUT_TYPES) ? CUT_TYPES : int'(cuts_in_use);
    for (int i = 0; i < n; i++) begin
      if (active > 0 && $urandom_range(99) < 85) t = $urandom_range(active - 1);
      else t = $urandom_range(CUT_TYPES - 1);
      roll = $urandom_range(99);
      if (roll < 20) v = '0;
      else if (roll < 55 && last_value[t] != 0) v = last_value[t];
      else if (roll < 72) v = $urandom_range(1, 4) * (($urandom_range(1) != 0) ? -1 : 1);
      else if (roll < 82) begin
        case ($urandom_range(3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end else v = $urandom;
      if (v != 0) last_value[t] = v;
      if ($urandom_range(99) < 5) next_event = $urandom;
      else next_event = next_event + $urandom_range(3);
      queue_report(t, v, next_event);
    end
  endtask

  initial begin
    for (int i = 0; i < CUT_TYPES; i++) last_value[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: open, keep, change and close at the value and event extremes.
    set_num_cuts(5'd16);
    queue_report(0, 32'sd0, 32'h0000_0000);           // zero with nothing open
    queue_report(0, 32'sh7FFF_FFFF, 32'h0000_0001);   // open
    queue_report(0, 32'sh7FFF_FFFF, 32'h0000_0002);   // same value stays open
    queue_report(0, 32'sh8000_0000, 32'h0000_0003);   // value changes: close and reopen
    queue_report(0, 32'sd0, 32'hFFFF_FFFF);           // close
    queue_report(15, -32'sd1, 32'hFFFF_FFFF);
    queue_report(15, 32'sd1, 32'h0000_0000);
    queue_report(15, 32'sd0, 32'h0000_0005);
    queue_report(15, 32'sd0, 32'h0000_0006);
    queue_report(7, 32'sh5555_5555, 32'hAAAA_AAAA);
    queue_report(8, 32'shAAAA_AAAA, 32'h5555_5555);
    queue_report(7, 32'shAAAA_AAAA, 32'h0000_0007);
    queue_report(8, 32'shAAAA_AAAA, 32'h0000_0008);
    queue_random_reports(150);
    drain_all();
    queue_random_reports(150);
    drain_all();

    // A long stretch with both sides running flat out.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_reports(150);
    drain_all();
    send_idle_pct = 32;
    recv_stall_pct = 32;

    // Narrow range: the boundary type is dropped, older table entries hide.
    set_num_cuts(5'd5);
    queue_report(4, 32'sd9, 32'h0000_1000);
    queue_report(5, 32'sd9, 32'h0000_1001);
    queue_report(15, 32'sd0, 32'h0000_1002);
    queue_random_reports(150);
    drain_all();

    // Nothing in use: every item is dropped.
    set_num_cuts(5'd0);
    queue_random_reports(20);
    drain_all();

    // Above the table size: every type is admitted again.
    set_num_cuts(5'd31);
    queue_random_reports(200);
    drain_all();

    set_num_cuts(5'd1);
    queue_random_reports(100);
    drain_all();

    set_num_cuts(5'd17);
    queue_random_reports(150);
    drain_all();

    set_num_cuts(5'd9);
    queue_random_reports(65);
    drain_all();

    $display("Covered %0d items (%0d dropped) over %0d num_cuts settings,",
             reports_sent, reports_ignored, settings_used);
    $display("  %0d intervals opened, %0d closed, %0d repeats kept open; %0d results checked.",
             intervals_opened, intervals_closed, intervals_kept, results_seen);
    if (errors == 0 && expected_rec_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("Timeout with %0d results still expected", expected_rec_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/cir_pkg.sv
src/cir_ctrl.sv
src/cir_datapath.sv
src/cut_interval_recorder_unit.sv
tb/cut_interval_recorder_unit_tb.sv
